@@ rtl/elw_pkg.sv @@
// package with shared types and constants for the escalating link watchdog
`timescale 1ns / 1ps

package elw_pkg;

    // configuration register field widths
    localparam int REG_W    = 20;
    localparam int MAXPC_W  = 8;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOST_RESTART = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_CYCLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_RESET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CYCLES   = 3'd4;

    // configuration reset values
    localparam logic [REG_W-1:0]   RST_HOST_RESTART = 20'd1380;
    localparam logic [REG_W-1:0]   RST_POWER_CYCLE  = 20'd1440;
    localparam logic [REG_W-1:0]   RST_HOLDOFF      = 20'd10;
    localparam logic [REG_W-1:0]   RST_CLEAN_RESET  = 20'd10080;
    localparam logic [MAXPC_W-1:0] RST_MAX_CYCLES   = 8'd3;

    // action codes
    localparam logic [1:0] ACT_NONE         = 2'd0;
    localparam logic [1:0] ACT_RESTART_HOST = 2'd1;
    localparam logic [1:0] ACT_POWER_CYCLE  = 2'd2;

    // phase codes
    localparam logic [1:0] PH_HOLDOFF = 2'd0;
    localparam logic [1:0] PH_HEALTHY = 2'd1;
    localparam logic [1:0] PH_FAILING = 2'd2;
    localparam logic [1:0] PH_BREAKER = 2'd3;

    // result field widths
    localparam int CYCLES_W = 8;
    localparam int FAILED_W = 20;

    // configuration register set
    typedef struct packed {
        logic [REG_W-1:0]   host_restart_ticks;
        logic [REG_W-1:0]   power_cycle_ticks;
        logic [REG_W-1:0]   holdoff_ticks_limit;
        logic [REG_W-1:0]   clean_reset_ticks;
        logic [MAXPC_W-1:0] max_power_cycles;
    } t_cfg;

endpackage

@@ rtl/escalating_link_watchdog.sv @@
// escalating link watchdog: tick counters, escalation decision and result register
// a result is registered and appears on the master side in the cycle after its tick is taken
// throughput: one tick per cycle while results are taken; the counters update in a single pass of logic
// ready on the slave side drops only while a result is held and not taken
// reset (i_rst_n low, synchronous) clears all counters and flags, restores the
// register defaults and empties the result register
`timescale 1ns / 1ps

module escalating_link_watchdog
    import elw_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // tick stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [0] target_alive, [7:1] zero
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [31:0]          o_m_tdata    // [1:0] action, [3:2] phase,
                                              // [11:4] power_cycles_done,
                                              // [31:12] failed_ticks
);

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    t_cfg cfg;

    // configuration registers
    elw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // watchdog state
    logic                   r_in_holdoff,     n_in_holdoff;
    logic [COUNT_WIDTH-1:0] r_holdoff_count,  n_holdoff_count;
    logic [COUNT_WIDTH-1:0] r_fail_count,     n_fail_count;
    logic [COUNT_WIDTH-1:0] r_clean_count,    n_clean_count;
    logic [CYCLES_W-1:0]    r_cycle_count,    n_cycle_count;
    logic                   r_host_restarted, n_host_restarted;

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [1:0]  n_action;
    logic [1:0]  n_phase;

    logic                   tick_acc;
    logic                   alive;
    logic [COUNT_WIDTH-1:0] hold_inc;
    logic [COUNT_WIDTH-1:0] clean_inc;
    logic [COUNT_WIDTH-1:0] fail_inc;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign tick_acc   = i_s_tvalid && o_s_tready;
    assign alive      = i_s_tdata[0];
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // saturating increments
    assign hold_inc  = (r_holdoff_count == CNT_MAX) ? CNT_MAX : r_holdoff_count + 1'b1;
    assign clean_inc = (r_clean_count == CNT_MAX) ? CNT_MAX : r_clean_count + 1'b1;
    assign fail_inc  = (r_fail_count == CNT_MAX) ? CNT_MAX : r_fail_count + 1'b1;

    // per-tick update
    always_comb begin
        n_in_holdoff     = r_in_holdoff;
        n_holdoff_count  = r_holdoff_count;
        n_fail_count     = r_fail_count;
        n_clean_count    = r_clean_count;
        n_cycle_count    = r_cycle_count;
        n_host_restarted = r_host_restarted;
        n_action         = ACT_NONE;
        n_phase          = PH_HOLDOFF;
        if (r_in_holdoff) begin
            // hold-off only counts ticks
            if (CMP_W'(hold_inc) >= CMP_W'(cfg.holdoff_ticks_limit)) begin
                n_in_holdoff    = 1'b0;
                n_holdoff_count = '0;
                n_fail_count    = '0;
            end else begin
                n_holdoff_count = hold_inc;
            end
        end else if (alive) begin
            // live tick extends the clean run
            n_phase          = PH_HEALTHY;
            n_fail_count     = '0;
            n_host_restarted = 1'b0;
            if (CMP_W'(clean_inc) >= CMP_W'(cfg.clean_reset_ticks)) begin
                n_cycle_count = '0;
                n_clean_count = '0;
            end else begin
                n_clean_count = clean_inc;
            end
        end else begin
            // failed tick escalates while the breaker is closed
            n_fail_count  = fail_inc;
            n_clean_count = '0;
            if (r_cycle_count >= cfg.max_power_cycles) begin
                n_phase = PH_BREAKER;
            end else begin
                n_phase = PH_FAILING;
                if (CMP_W'(fail_inc) >= CMP_W'(cfg.host_restart_ticks)
                        && !r_host_restarted) begin
                    n_host_restarted = 1'b1;
                    n_action         = ACT_RESTART_HOST;
                end else if (CMP_W'(fail_inc) >= CMP_W'(cfg.power_cycle_ticks)) begin
                    n_cycle_count    = r_cycle_count + 1'b1;
                    n_in_holdoff     = 1'b1;
                    n_holdoff_count  = '0;
                    n_host_restarted = 1'b0;
                    n_action         = ACT_POWER_CYCLE;
                end
            end
        end
    end

    // state registers, updated on each tick transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_holdoff     <= 1'b0;
            r_holdoff_count  <= '0;
            r_fail_count     <= '0;
            r_clean_count    <= '0;
            r_cycle_count    <= '0;
            r_host_restarted <= 1'b0;
        end else if (tick_acc) begin
            r_in_holdoff     <= n_in_holdoff;
            r_holdoff_count  <= n_holdoff_count;
            r_fail_count     <= n_fail_count;
            r_clean_count    <= n_clean_count;
            r_cycle_count    <= n_cycle_count;
            r_host_restarted <= n_host_restarted;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_out_data <= {FAILED_W'(n_fail_count), n_cycle_count, n_phase, n_action};
        end
    end

    // an action is only ever raised on a failing tick
    a_action_failing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[1:0] != ACT_NONE)) |-> (r_out_data[3:2] == PH_FAILING))
        else $error("action raised outside the failing phase");

    // a power cycle always enters hold-off
    a_pc_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && (n_action == ACT_POWER_CYCLE)) |=> r_in_holdoff)
        else $error("power cycle did not start hold-off");

    // the restart flag is clear for the whole hold-off
    a_holdoff_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_holdoff |-> !r_host_restarted)
        else $error("host restart flag set during hold-off");

    // state moves only on a tick transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_acc |=> ($stable(r_fail_count) && $stable(r_cycle_count)
                       && $stable(r_in_holdoff)))
        else $error("state changed without a tick");

    // a result waiting while the sink stalls is not overwritten
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("tick taken while a result is stalled");

endmodule

@@ rtl/elw_cfg.sv @@
// configuration register file for the escalating link watchdog
`timescale 1ns / 1ps

module elw_cfg
    import elw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // decode a write transfer, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HOST_RESTART: n_cfg.host_restart_ticks  = i_cfg_data;
                REG_POWER_CYCLE:  n_cfg.power_cycle_ticks   = i_cfg_data;
                REG_HOLDOFF:      n_cfg.holdoff_ticks_limit = i_cfg_data;
                REG_CLEAN_RESET:  n_cfg.clean_reset_ticks   = i_cfg_data;
                REG_MAX_CYCLES:   n_cfg.max_power_cycles    = i_cfg_data[MAXPC_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    // register set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_restart_ticks  <= RST_HOST_RESTART;
            r_cfg.power_cycle_ticks   <= RST_POWER_CYCLE;
            r_cfg.holdoff_ticks_limit <= RST_HOLDOFF;
            r_cfg.clean_reset_ticks   <= RST_CLEAN_RESET;
            r_cfg.max_power_cycles    <= RST_MAX_CYCLES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ bench/tb_escalating_link_watchdog.sv @@
// self-checking bench for the escalating link watchdog: directed table, then random tick runs
`timescale 1ns / 1ps

module tb_escalating_link_watchdog;
    import elw_pkg::*;

    localparam int CNT_W       = 20;
    localparam int IDLE_LIMIT  = 500;   // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 60;    // long receiver hold-off
    localparam int PHASES      = 10;
    localparam int PHASE_TICKS = 88;

    // indexes outside the register map, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    // result layout, same packing as o_m_tdata
    typedef struct packed {
        logic [FAILED_W-1:0] failed_ticks;
        logic [CYCLES_W-1:0] cycles_done;
        logic [1:0]          phase;
        logic [1:0]          action;
    } t_watch_result;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  alive;
        logic [CFG_IDX_W-1:0]  idx;
        logic [REG_W-1:0]      data;
        bit                    typed;
        t_watch_result         want;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = '0;   // [0] target_alive, [7:1] zero
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [31:0]          o_m_tdata;          // [1:0] action, [3:2] phase,
                                              // [11:4] power_cycles_done,
                                              // [31:12] failed_ticks

    // watchdog state mirror
    t_cfg             watch_cfg;
    logic             pr_in_holdoff;
    logic [CNT_W-1:0] pr_holdoff_cnt;
    logic [CNT_W-1:0] pr_fail;
    logic [CNT_W-1:0] pr_clean;
    logic [7:0]       pr_cycles;
    logic             pr_restarted;

    t_watch_result pending_results[$];
    t_stim_row     dir_rows[$];
    bit            use_typed;
    t_watch_result typed_result;

    int errors;
    int idle_cycles;
    int results_seen;
    int ticks_taken;
    int settings_applied;
    int restarts_seen;
    int power_cycles_seen;
    int holdoff_seen;
    int breaker_seen;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;

    escalating_link_watchdog #(
        .COUNT_WIDTH(CNT_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturating increment
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // register write as the block sees it
    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [REG_W-1:0] data);
        case (idx)
            REG_HOST_RESTART: watch_cfg.host_restart_ticks  = data;
            REG_POWER_CYCLE:  watch_cfg.power_cycle_ticks   = data;
            REG_HOLDOFF:      watch_cfg.holdoff_ticks_limit = data;
            REG_CLEAN_RESET:  watch_cfg.clean_reset_ticks   = data;
            REG_MAX_CYCLES:   watch_cfg.max_power_cycles    = data[MAXPC_W-1:0];
            default: ;
        endcase
    endfunction

    // one monitoring tick: update the mirror and return the expected result
    function automatic t_watch_result predict_tick(input logic alive);
        t_watch_result    r;
        logic [CNT_W-1:0] h;
        r.action = ACT_NONE;
        if (pr_in_holdoff) begin
            h = bump(pr_holdoff_cnt);
            r.phase = PH_HOLDOFF;
            if (h >= watch_cfg.holdoff_ticks_limit) begin
                pr_in_holdoff  = 1'b0;
                pr_holdoff_cnt = '0;
                pr_fail        = '0;
            end else begin
                pr_holdoff_cnt = h;
            end
        end else if (alive) begin
            r.phase      = PH_HEALTHY;
            pr_fail      = '0;
            pr_restarted = 1'b0;
            pr_clean     = bump(pr_clean);
            if (pr_clean >= watch_cfg.clean_reset_ticks) begin
                pr_cycles = '0;
                pr_clean  = '0;
            end
        end else begin
            pr_fail  = bump(pr_fail);
            pr_clean = '0;
            if (pr_cycles >= watch_cfg.max_power_cycles) begin
                r.phase = PH_BREAKER;
            end else begin
                r.phase = PH_FAILING;
                // host restart wins when both thresholds are met
                if (pr_fail >= watch_cfg.host_restart_ticks && !pr_restarted) begin
                    pr_restarted = 1'b1;
                    r.action     = ACT_RESTART_HOST;
                end else if (pr_fail >= watch_cfg.power_cycle_ticks) begin
                    pr_cycles      = pr_cycles + 1'b1;
                    pr_in_holdoff  = 1'b1;
                    pr_holdoff_cnt = '0;
                    pr_restarted   = 1'b0;
                    r.action       = ACT_POWER_CYCLE;
                end
            end
        end
        r.cycles_done  = pr_cycles;
        r.failed_ticks = pr_fail;
        return r;
    endfunction

    function automatic t_watch_result result_of(input logic [1:0] act, input logic [1:0] ph,
                                                input int cyc, input int fails);
        t_watch_result r;
        r.action       = act;
        r.phase        = ph;
        r.cycles_done  = CYCLES_W'(cyc);
        r.failed_ticks = FAILED_W'(fails);
        return r;
    endfunction

    function automatic void add_tick(input logic alive, input bit typed = 1'b0,
                                     input t_watch_result want = '0);
        t_stim_row r;
        r.kind  = ROW_TICK;
        r.alive = alive;
        r.idx   = '0;
        r.data  = '0;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [REG_W-1:0] data);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.alive = 1'b0;
        r.idx   = idx;
        r.data  = data;
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    endtask

    // one tick transfer, entered and left at a falling edge
    task automatic send_tick(input logic alive);
        logic junk;
        while ($urandom_range(99) < send_idle_pct) begin
            junk = 1'($urandom_range(1));
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {7'd0, junk};
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, alive};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // one register write, valid dropped after it is taken
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop offering ticks and let every pending result drain
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // result receiver with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // transfer monitor, result checker and no-progress watchdog
    always @(posedge i_clk) begin
        t_watch_result got;
        t_watch_result want;
        bit            moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            // expectation first, so a same-edge result still finds it
            if (i_s_tvalid && o_s_tready) begin
                want = predict_tick(i_s_tdata[0]);
                if (use_typed)
                    want = typed_result;
                pending_results.push_back(want);
                ticks_taken++;
                moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                results_seen++;
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, raw data", o_m_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.action !== want.action)
                        report_mismatch("action", 32'(got.action), 32'(want.action));
                    if (got.phase !== want.phase)
                        report_mismatch("phase", 32'(got.phase), 32'(want.phase));
                    if (got.cycles_done !== want.cycles_done)
                        report_mismatch("power_cycles_done", 32'(got.cycles_done),
                                        32'(want.cycles_done));
                    if (got.failed_ticks !== want.failed_ticks)
                        report_mismatch("failed_ticks", 32'(got.failed_ticks),
                                        32'(want.failed_ticks));
                    if (want.action == ACT_RESTART_HOST) restarts_seen++;
                    if (want.action == ACT_POWER_CYCLE) power_cycles_seen++;
                    if (want.phase == PH_HOLDOFF) holdoff_seen++;
                    if (want.phase == PH_BREAKER) breaker_seen++;
                end
            end
        end
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results pending",
                     IDLE_LIMIT, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        int                   p;
        int                   items;
        int                   len;
        int                   roll;
        int                   fail_span;
        int                   live_span;
        int                   host;
        int                   power;
        int                   holdoff;
        int                   clean;
        int                   maxc;
        logic                 alive;
        logic [REG_W-1:0]     max_data;
        logic [CFG_IDX_W-1:0] odd_idx;

        watch_cfg.host_restart_ticks  = RST_HOST_RESTART;
        watch_cfg.power_cycle_ticks   = RST_POWER_CYCLE;
        watch_cfg.holdoff_ticks_limit = RST_HOLDOFF;
        watch_cfg.clean_reset_ticks   = RST_CLEAN_RESET;
        watch_cfg.max_power_cycles    = RST_MAX_CYCLES;
        pr_in_holdoff  = 1'b0;
        pr_holdoff_cnt = '0;
        pr_fail        = '0;
        pr_clean       = '0;
        pr_cycles      = '0;
        pr_restarted   = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults straight after reset
        add_tick(1'b1, 1'b1, result_of(ACT_NONE, PH_HEALTHY, 0, 0));
        add_tick(1'b0, 1'b1, result_of(ACT_NONE, PH_FAILING, 0, 1));
        // small thresholds; stray writes to unmapped indexes must change nothing
        add_cfg(REG_HOST_RESTART, 20'd2);
        add_cfg(REG_POWER_CYCLE, 20'd4);
        add_cfg(REG_HOLDOFF, 20'd2);
        add_cfg(REG_CLEAN_RESET, 20'd3);
        add_cfg(REG_MAX_CYCLES, 20'hFF302);
        add_cfg(REG_UNUSED_LO, 20'd0);
        add_cfg(REG_UNUSED_HI, 20'd0);
        // restart, then power cycle, then hold-off
        add_tick(1'b0, 1'b1, result_of(ACT_RESTART_HOST, PH_FAILING, 0, 2));
        add_tick(1'b0);
        add_tick(1'b0, 1'b1, result_of(ACT_POWER_CYCLE, PH_FAILING, 1, 4));
        add_tick(1'b1);
        add_tick(1'b0, 1'b1, result_of(ACT_NONE, PH_HOLDOFF, 1, 0));
        // restart again, a live tick, and a second escalation
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b0);
        // breaker open, then a clean run clears the cycle count
        add_tick(1'b0, 1'b1, result_of(ACT_NONE, PH_BREAKER, 2, 1));
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1, 1'b1, result_of(ACT_NONE, PH_HEALTHY, 0, 0));
        // zero thresholds are met at once, zero max keeps the breaker open
        add_cfg(REG_HOST_RESTART, 20'd0);
        add_cfg(REG_POWER_CYCLE, 20'd0);
        add_cfg(REG_HOLDOFF, 20'd0);
        add_cfg(REG_CLEAN_RESET, 20'd0);
        add_cfg(REG_MAX_CYCLES, 20'd0);
        add_tick(1'b0, 1'b1, result_of(ACT_NONE, PH_BREAKER, 0, 1));
        add_cfg(REG_MAX_CYCLES, 20'd1);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b1);

        // walk the directed table
        settings_applied = 4;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                use_typed    = dir_rows[i].typed;
                typed_result = dir_rows[i].want;
                send_tick(dir_rows[i].alive);
            end
        end
        use_typed = 1'b0;

        // random phases, each with its own register setting and idling mode
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            host    = $urandom_range(1, 6);
            power   = $urandom_range(1, 10);
            holdoff = $urandom_range(0, 5);
            clean   = $urandom_range(1, 12);
            maxc    = $urandom_range(1, 4);
            case (p)
                1: begin
                    host    = 0;
                    power   = 0;
                    holdoff = 0;
                    clean   = 0;
                end
                3: begin
                    host    = 20'hFFFFF;
                    power   = 20'hFFFFF;
                    holdoff = 20'hFFFFF;
                    clean   = 20'hFFFFF;
                    maxc    = 255;
                end
                5: maxc = 0;
                7: maxc = 255;
                8: holdoff = 20'hFFFFF;
                9: begin
                    host  = 1;
                    power = 1;
                end
                default: ;
            endcase
            max_data        = REG_W'($urandom());
            max_data[7:0]   = 8'(maxc);
            odd_idx         = CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
            cfg_write(REG_HOST_RESTART, REG_W'(host));
            cfg_write(REG_POWER_CYCLE, REG_W'(power));
            cfg_write(odd_idx, REG_W'($urandom()));
            cfg_write(REG_HOLDOFF, REG_W'(holdoff));
            cfg_write(REG_CLEAN_RESET, REG_W'(clean));
            cfg_write(REG_MAX_CYCLES, max_data);
            settings_applied++;

            // idling mode changes away from the receiver's sampling edge
            @(posedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (p == 4)
                hold_requests++;
            @(negedge i_clk);

            // bursts of failed or live ticks sized to the thresholds, plus noise
            fail_span = ((power > 20) ? 20 : power) + ((holdoff > 8) ? 8 : holdoff) + 3;
            live_span = ((clean > 20) ? 20 : clean) + 2;
            items = 0;
            while (items < PHASE_TICKS) begin
                roll = $urandom_range(99);
                if (roll < 45)
                    len = $urandom_range(1, fail_span);
                else if (roll < 80)
                    len = $urandom_range(1, live_span);
                else
                    len = $urandom_range(1, 4);
                repeat (len) begin
                    if (roll < 45)
                        alive = 1'b0;
                    else if (roll < 80)
                        alive = 1'b1;
                    else
                        alive = 1'($urandom_range(1));
                    send_tick(alive);
                    items++;
                end
            end
        end

        // drain and settle
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("run covered %0d ticks under %0d register settings, %0d results checked",
                 ticks_taken, settings_applied, results_seen);
        $display("with %0d host restarts, %0d power cycles, %0d hold-off and %0d breaker ticks",
                 restarts_seen, power_cycles_seen, holdoff_seen, breaker_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
